### hw/rtl/comb_allpass_reverb_defines.svh
// Assertion macros shared by the reverb checker.
// Depends on nothing; included by files that assert.
`ifndef COMB_ALLPASS_REVERB_DEFINES_SVH
`define COMB_ALLPASS_REVERB_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define CAR_ASSERT_IMP(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Next-cycle implication checked outside reset.
`define CAR_ASSERT_NXT(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

### hw/rtl/car_pkg.sv
// Package for the comb/allpass reverb: widths, tuning tables, helpers.
// Depends on nothing.
`timescale 1ns / 1ps
package car_pkg;
   localparam int IntWidth = 24;
   localparam int CfgWidth = 16;
   localparam logic [2:0] REG_FEEDBACK = 3'd0;
   localparam logic [2:0] REG_DAMPING  = 3'd1;
   localparam logic [2:0] REG_AP_GAIN  = 3'd2;
   localparam logic [2:0] REG_WET      = 3'd3;
   localparam logic [2:0] REG_DRY      = 3'd4;
   localparam logic [2:0] REG_FREEZE   = 3'd5;

   typedef logic signed [IntWidth-1:0] int_type;

   typedef struct packed {
      logic [15:0] feedback;
      logic [14:0] damping;
      logic [14:0] allpass_gain;
      logic [15:0] wet_gain;
      logic [15:0] dry_gain;
      logic        freeze;
   } cfg_type;

   function automatic logic [13:0] comb_len_tab(input logic [3:0] i);
      logic [13:0] r;
      case (i)
         4'd0: r = 14'd1116;  4'd1: r = 14'd1188;  4'd2: r = 14'd1277;  4'd3: r = 14'd1356;
         4'd4: r = 14'd1422;  4'd5: r = 14'd1491;  4'd6: r = 14'd1557;  4'd7: r = 14'd1617;
         4'd8: r = 14'd1139;  4'd9: r = 14'd1211;  4'd10: r = 14'd1300; 4'd11: r = 14'd1379;
         4'd12: r = 14'd1445; 4'd13: r = 14'd1514; 4'd14: r = 14'd1580; default: r = 14'd1640;
      endcase
      return r;
   endfunction

   function automatic logic [12:0] ap_len_tab(input logic [2:0] i);
      logic [12:0] r;
      case (i)
         3'd0: r = 13'd556; 3'd1: r = 13'd441; 3'd2: r = 13'd341; 3'd3: r = 13'd225;
         3'd4: r = 13'd579; 3'd5: r = 13'd464; 3'd6: r = 13'd364; default: r = 13'd248;
      endcase
      return r;
   endfunction

   // Round a Q.15 product sum to nearest, ties up (arithmetic shift floors).
   function automatic logic signed [47:0] q15_round(input logic signed [47:0] p);
      logic signed [47:0] v;
      v = p + 48'sd16384;
      return v >>> 15;
   endfunction

   function automatic int_type sat_int(input logic signed [47:0] v);
      int_type r;
      if (v > 48'sd8388607) r = 24'sh7FFFFF;
      else if (v < -48'sd8388608) r = 24'sh800000;
      else r = v[IntWidth-1:0];
      return r;
   endfunction
endpackage

### hw/rtl/car_stream_if.sv
// Valid/ready stream interface for one sample word.
// Depends on nothing.
`timescale 1ns / 1ps
interface car_stream_if #(parameter int W = 16);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/car_mac.sv
// Shared multiply-accumulate unit: one 25x18 product per enabled cycle into an accumulator.
// Depends on car_pkg.
`timescale 1ns / 1ps
module car_mac (
   input  logic                clock,
   input  logic                clear,
   input  logic                enable,
   input  logic signed [24:0]  op_a,
   input  logic signed [17:0]  op_b,
   output logic signed [47:0]  acc
);
   import car_pkg::*;
   logic signed [47:0] acc_ff, acc_in;
   logic signed [47:0] prod;
   assign prod = 48'(op_a) * 48'(op_b);
   always_comb begin
      acc_in = acc_ff;
      if (enable) acc_in = (clear ? 48'sd0 : acc_ff) + prod;
   end
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end
   assign acc = acc_ff;
endmodule

### hw/rtl/comb_allpass_reverb.sv
// Top level of the comb/allpass reverb: sequencer, delay memories, config registers.
// Depends on car_pkg, car_stream_if and car_mac.
`timescale 1ns / 1ps
// One sample word enters, runs through NUM_COMBS low-pass feedback combs and then
// NUM_ALLPASSES series allpasses, and is mixed with the dry word and saturated.
// A single multiply-accumulate unit does all products under a small sequencer:
// three products per comb, one per allpass and two for the mix, each with a
// memory read or write turn. The block is not ready while a word is worked on.
// A finished word goes to the output register and the next word is taken at
// once; if that next word finishes while the register is still full, it waits
// until the register empties. After reset a clearing pass writes zero to every
// delay entry, one comb and one allpass entry per cycle, until the larger of
// NUM_COMBS*COMB_MAX_LEN and NUM_ALLPASSES*ALLPASS_MAX_LEN entries is cleared;
// configuration writes are taken during it.
module comb_allpass_reverb #(
   parameter int NUM_COMBS       = 8,
   parameter int NUM_ALLPASSES   = 4,
   parameter int COMB_MAX_LEN    = 2048,
   parameter int ALLPASS_MAX_LEN = 1024,
   parameter int SAMPLE_WIDTH    = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   car_stream_if.sink            req,
   car_stream_if.source          rsp,
   input  logic                  csr_we,
   input  logic [2:0]            csr_index,
   input  logic [car_pkg::CfgWidth-1:0] csr_data
);
   import car_pkg::*;

   localparam int CW   = $clog2(NUM_COMBS);
   localparam int AW   = $clog2(NUM_ALLPASSES);
   localparam int CLW  = $clog2(COMB_MAX_LEN);
   localparam int ALW  = $clog2(ALLPASS_MAX_LEN);
   localparam int CDEP = NUM_COMBS * COMB_MAX_LEN;
   localparam int ADEP = NUM_ALLPASSES * ALLPASS_MAX_LEN;
   localparam int CAW  = $clog2(CDEP);
   localparam int AAW  = $clog2(ADEP);
   localparam int CIW  = (CW > 0) ? CW : 1;
   localparam int AIW  = (AW > 0) ? AW : 1;
   localparam int CLRN = (CDEP > ADEP) ? CDEP : ADEP;
   localparam int CNT  = $clog2(CLRN) + 1;

   // Sequencer states.
   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_CRD   = 4'd2;  // comb tail read issued
   localparam logic [3:0] S_CLP1  = 4'd3;  // (1-d)*tail
   localparam logic [3:0] S_CLP2  = 4'd4;  // + d*state
   localparam logic [3:0] S_CFB   = 4'd5;  // lp saturated; fb*lp
   localparam logic [3:0] S_CWR   = 4'd6;  // write yn, accumulate
   localparam logic [3:0] S_ARD   = 4'd7;
   localparam logic [3:0] S_AG    = 4'd8;  // g*tail
   localparam logic [3:0] S_AWR   = 4'd9;  // write v, form s
   localparam logic [3:0] S_MIX1  = 4'd10;
   localparam logic [3:0] S_MIX2  = 4'd11;
   localparam logic [3:0] S_OUT   = 4'd12;
   localparam logic [3:0] S_HOLD  = 4'd13;

   cfg_type cfg_ff;
   logic [3:0] state_ff;
   logic [CNT-1:0] clr_ff;
   logic [CIW-1:0] ci_ff;
   logic [AIW-1:0] ai_ff;
   logic signed [SAMPLE_WIDTH-1:0] x_ff;
   int_type tail_ff, s_ff;
   logic signed [47:0] sum_ff;
   logic [CLW-1:0] cpos_ff [NUM_COMBS];
   logic [ALW-1:0] apos_ff [NUM_ALLPASSES];
   int_type cstate_ff [NUM_COMBS];
   logic rsp_valid_ff;
   logic [SAMPLE_WIDTH-1:0] rsp_data_ff;

   int_type comb_mem [CDEP];
   int_type ap_mem [ADEP];
   int_type comb_rd_ff, ap_rd_ff;

   logic [15:0] fb_eff;
   logic [14:0] d_eff;
   assign fb_eff = cfg_ff.freeze ? 16'd32768 : cfg_ff.feedback;
   assign d_eff  = cfg_ff.freeze ? 15'd0 : cfg_ff.damping;

   logic [CLW:0] clen;
   logic [ALW:0] alen;
   always_comb begin
      logic [13:0] tl;
      logic [12:0] al;
      tl = comb_len_tab(4'(ci_ff));
      al = ap_len_tab(3'(ai_ff));
      clen = (tl > 14'(COMB_MAX_LEN)) ? (CLW+1)'(COMB_MAX_LEN) : (CLW+1)'(tl);
      alen = (al > 13'(ALLPASS_MAX_LEN)) ? (ALW+1)'(ALLPASS_MAX_LEN) : (ALW+1)'(al);
   end

   logic [CAW-1:0] caddr;
   logic [AAW-1:0] aaddr;
   logic [CLW-1:0] cpos_cur;
   logic [ALW-1:0] apos_cur;
   assign cpos_cur = cpos_ff[ci_ff];
   assign apos_cur = apos_ff[ai_ff];
   assign caddr = CAW'(ci_ff) * CAW'(COMB_MAX_LEN) + CAW'(cpos_cur);
   assign aaddr = AAW'(ai_ff) * AAW'(ALLPASS_MAX_LEN) + AAW'(apos_cur);

   // Shared multiply-accumulate.
   logic mac_clear, mac_en;
   logic signed [24:0] mac_a;
   logic signed [17:0] mac_b;
   logic signed [47:0] acc;
   car_mac u_mac (.clock(clock), .clear(mac_clear), .enable(mac_en),
      .op_a(mac_a), .op_b(mac_b), .acc(acc));

   int_type lp_sat, yn, v_sat, s_next;
   logic signed [47:0] gt, y_rnd;
   logic signed [SAMPLE_WIDTH-1:0] y_sat;
   localparam logic signed [47:0] SMax = (48'sd1 <<< (SAMPLE_WIDTH-1)) - 48'sd1;
   localparam logic signed [47:0] SMin = -SMax - 48'sd1;
   always_comb begin
      lp_sat = sat_int(q15_round(acc));
      yn     = sat_int(48'(x_ff) + q15_round(acc));
      gt     = q15_round(acc);
      v_sat  = sat_int(48'(s_ff) + gt);
      s_next = sat_int(-48'(v_sat) + 48'(tail_ff) + gt);
      y_rnd  = q15_round(acc);
      if (y_rnd > SMax) y_sat = SMax[SAMPLE_WIDTH-1:0];
      else if (y_rnd < SMin) y_sat = SMin[SAMPLE_WIDTH-1:0];
      else y_sat = y_rnd[SAMPLE_WIDTH-1:0];
   end

   always_comb begin
      mac_clear = 1'b0; mac_en = 1'b0; mac_a = '0; mac_b = '0;
      case (state_ff)
         S_CLP1: begin
            mac_en = 1'b1; mac_clear = 1'b1;
            mac_a = 25'(comb_rd_ff); mac_b = 18'sd32768 - 18'(d_eff);
         end
         S_CLP2: begin
            mac_en = 1'b1; mac_a = 25'(cstate_ff[ci_ff]); mac_b = 18'(d_eff);
         end
         S_CFB: begin
            mac_en = 1'b1; mac_clear = 1'b1; mac_a = 25'(lp_sat); mac_b = 18'(fb_eff);
         end
         S_AG: begin
            mac_en = 1'b1; mac_clear = 1'b1; mac_a = 25'(ap_rd_ff);
            mac_b = 18'(cfg_ff.allpass_gain);
         end
         S_MIX1: begin
            mac_en = 1'b1; mac_clear = 1'b1; mac_a = 25'(s_ff); mac_b = 18'(cfg_ff.wet_gain);
         end
         S_MIX2: begin
            mac_en = 1'b1; mac_a = 25'(x_ff); mac_b = 18'(cfg_ff.dry_gain);
         end
         default: ;
      endcase
   end

   // Memories: write in clocked blocks, registered reads.
   logic comb_we, ap_we;
   logic [CAW-1:0] comb_wa;
   logic [AAW-1:0] ap_wa;
   int_type comb_wd, ap_wd;
   always_comb begin
      comb_we = 1'b0; ap_we = 1'b0;
      comb_wa = caddr; ap_wa = aaddr; comb_wd = yn; ap_wd = v_sat;
      if (state_ff == S_CLEAR) begin
         comb_we = (clr_ff < CNT'(CDEP)); comb_wa = clr_ff[CAW-1:0]; comb_wd = '0;
         ap_we = (clr_ff < CNT'(ADEP)); ap_wa = clr_ff[AAW-1:0]; ap_wd = '0;
      end else if (state_ff == S_CWR) comb_we = 1'b1;
      else if (state_ff == S_AWR) ap_we = 1'b1;
   end
   always_ff @(posedge clock) begin
      if (comb_we) comb_mem[comb_wa] <= comb_wd;
      comb_rd_ff <= comb_mem[caddr];
   end
   always_ff @(posedge clock) begin
      if (ap_we) ap_mem[ap_wa] <= ap_wd;
      ap_rd_ff <= ap_mem[aaddr];
   end

   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

   logic last_comb, last_ap;
   assign last_comb = (ci_ff == CIW'(NUM_COMBS - 1));
   assign last_ap   = (ai_ff == AIW'(NUM_ALLPASSES - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff <= '0;
         ci_ff <= '0; ai_ff <= '0;
         rsp_valid_ff <= 1'b0;
         cfg_ff <= '{feedback: 16'd27853, damping: 15'd3277, allpass_gain: 15'd16384,
                     wet_gain: 16'd33, dry_gain: 16'd16423, freeze: 1'b0};
         for (int i = 0; i < NUM_COMBS; i++) begin
            cpos_ff[i] <= '0; cstate_ff[i] <= '0;
         end
         for (int i = 0; i < NUM_ALLPASSES; i++) apos_ff[i] <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               REG_FEEDBACK: cfg_ff.feedback     <= csr_data;
               REG_DAMPING:  cfg_ff.damping      <= csr_data[14:0];
               REG_AP_GAIN:  cfg_ff.allpass_gain <= csr_data[14:0];
               REG_WET:      cfg_ff.wet_gain     <= csr_data;
               REG_DRY:      cfg_ff.dry_gain     <= csr_data;
               REG_FREEZE:   cfg_ff.freeze       <= csr_data[0];
               default: ;
            endcase
         end
         // In S_HOLD the output register is reloaded below, so it is not cleared here.
         if (rsp.valid && rsp.ready && state_ff != S_HOLD) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == CNT'(CLRN - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: if (req.valid) begin
               x_ff <= req.data; sum_ff <= '0; ci_ff <= '0; ai_ff <= '0;
               state_ff <= S_CRD;
            end
            S_CRD:  state_ff <= S_CLP1;
            S_CLP1: state_ff <= S_CLP2;
            S_CLP2: state_ff <= S_CFB;
            S_CFB: begin
               cstate_ff[ci_ff] <= lp_sat;
               state_ff <= S_CWR;
            end
            S_CWR: begin
               sum_ff <= sum_ff + 48'(yn);
               cpos_ff[ci_ff] <= ((CLW+1)'(cpos_cur) + 1'b1 == clen) ? '0 : cpos_cur + 1'b1;
               if (last_comb) begin
                  s_ff <= sat_int(sum_ff + 48'(yn));
                  state_ff <= S_ARD;
               end else begin
                  ci_ff <= ci_ff + 1'b1;
                  state_ff <= S_CRD;
               end
            end
            S_ARD: state_ff <= S_AG;
            S_AG: begin
               tail_ff <= ap_rd_ff;
               state_ff <= S_AWR;
            end
            S_AWR: begin
               s_ff <= s_next;
               apos_ff[ai_ff] <= ((ALW+1)'(apos_cur) + 1'b1 == alen) ? '0 : apos_cur + 1'b1;
               if (last_ap) state_ff <= S_MIX1;
               else begin
                  ai_ff <= ai_ff + 1'b1;
                  state_ff <= S_ARD;
               end
            end
            S_MIX1: state_ff <= S_MIX2;
            S_MIX2: state_ff <= S_OUT;
            S_OUT: state_ff <= S_HOLD;
            S_HOLD: if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_ff <= 1'b1;
               rsp_data_ff <= y_sat;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

### hw/rtl/car_checker.sv
// Port-level checker for the reverb, bound to the top level.
// Depends on comb_allpass_reverb_defines.svh.
`timescale 1ns / 1ps
`include "comb_allpass_reverb_defines.svh"
module car_checker #(parameter int SAMPLE_WIDTH = 16) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [SAMPLE_WIDTH-1:0] rsp_data
);
   `CAR_ASSERT_NXT(a_busy, clock, reset, req_valid && req_ready, !req_ready,
      "block took a word while busy")
   `CAR_ASSERT_NXT(a_noout, clock, reset, req_valid && req_ready,
      !(rsp_valid && $rose(rsp_valid)), "result appeared right after accept")
   `CAR_ASSERT_NXT(a_hold, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data),
      "stalled result changed")
endmodule

bind comb_allpass_reverb car_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_car_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data));

### tb/comb_allpass_reverb_checker.sv
// Checker for the comb/allpass reverb: follows the register port and both word channels,
// predicts every output word and compares. Depends on car_pkg and car_stream_if.
`timescale 1ns / 1ps
module comb_allpass_reverb_checker (
   input  logic        clock,
   input  logic        reset,
   car_stream_if       req,
   car_stream_if       rsp,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data,
   output int          pending,
   output int          errors
);
   import car_pkg::*;

   localparam int NCOMB = 8;
   localparam int NAP = 4;
   localparam int CSTORE = 2048;
   localparam int ASTORE = 1024;
   localparam int COMB_TAPS[NCOMB] = '{1116, 1188, 1277, 1356, 1422, 1491, 1557, 1617};
   localparam int AP_TAPS[NAP] = '{556, 441, 341, 225};

   logic [15:0] fb_reg, wet_reg, dry_reg;
   logic [14:0] damp_reg, apg_reg;
   logic        freeze_reg;

   int comb_line[NCOMB][CSTORE];
   int comb_lp[NCOMB];
   int comb_ptr[NCOMB];
   int ap_line[NAP][ASTORE];
   int ap_ptr[NAP];

   logic [15:0] expected_words[$];

   assign pending = expected_words.size();

   function automatic longint rnd15(input longint p);
      return (p + 64'sd16384) >>> 15;
   endfunction

   function automatic longint clip(input longint v, input int bits);
      longint hi;
      hi = (64'sd1 <<< (bits - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   // Runs one dry word through combs, allpasses and the mix, updating the delay lines.
   function automatic logic [15:0] reverb_word(input logic [15:0] raw);
      longint x, fb, d, g, sum, s, tail, lp, yn, gt, v, y;
      int pos;
      x = longint'($signed(raw));
      fb = freeze_reg ? 32768 : longint'(fb_reg);
      d = freeze_reg ? 0 : longint'(damp_reg);
      g = longint'(apg_reg);
      sum = 0;
      for (int i = 0; i < NCOMB; i++) begin
         pos = comb_ptr[i];
         tail = comb_line[i][pos];
         lp = clip(rnd15((32768 - d) * tail + d * longint'(comb_lp[i])), 24);
         comb_lp[i] = int'(lp);
         yn = clip(x + rnd15(fb * lp), 24);
         comb_line[i][pos] = int'(yn);
         comb_ptr[i] = (pos + 1) % COMB_TAPS[i];
         sum += yn;
      end
      s = clip(sum, 24);
      for (int i = 0; i < NAP; i++) begin
         pos = ap_ptr[i];
         tail = ap_line[i][pos];
         gt = rnd15(g * tail);
         v = clip(s + gt, 24);
         ap_line[i][pos] = int'(v);
         ap_ptr[i] = (pos + 1) % AP_TAPS[i];
         s = clip(-v + tail + gt, 24);
      end
      y = clip(rnd15(longint'(wet_reg) * s + longint'(dry_reg) * x), 16);
      return y[15:0];
   endfunction

   always @(posedge clock) begin
      logic [15:0] want;
      if (reset) begin
         fb_reg <= 16'd27853;
         damp_reg <= 15'd3277;
         apg_reg <= 15'd16384;
         wet_reg <= 16'd33;
         dry_reg <= 16'd16423;
         freeze_reg <= 1'b0;
         for (int i = 0; i < NCOMB; i++) begin
            comb_lp[i] = 0;
            comb_ptr[i] = 0;
            for (int j = 0; j < CSTORE; j++) comb_line[i][j] = 0;
         end
         for (int i = 0; i < NAP; i++) begin
            ap_ptr[i] = 0;
            for (int j = 0; j < ASTORE; j++) ap_line[i][j] = 0;
         end
         expected_words.delete();
         errors <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_FEEDBACK: fb_reg <= csr_data;
               REG_DAMPING:  damp_reg <= csr_data[14:0];
               REG_AP_GAIN:  apg_reg <= csr_data[14:0];
               REG_WET:      wet_reg <= csr_data;
               REG_DRY:      dry_reg <= csr_data;
               REG_FREEZE:   freeze_reg <= csr_data[0];
               default: ;
            endcase
         end
         if (req.valid && req.ready) expected_words.push_back(reverb_word(req.data));
         if (rsp.valid && rsp.ready) begin
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected word, expected none, actual %h", $time, rsp.data);
               errors <= errors + 1;
            end else begin
               want = expected_words.pop_front();
               if (rsp.data !== want) begin
                  $display("%0t: sample_out mismatch, expected %h, actual %h",
                           $time, want, rsp.data);
                  errors <= errors + 1;
               end
            end
         end
      end
   end
endmodule

### tb/comb_allpass_reverb_tb.sv
// Top of the reverb testbench: clock, reset, stimulus, register phases and the verdict.
// Depends on car_pkg, car_stream_if, comb_allpass_reverb and comb_allpass_reverb_checker.
`timescale 1ns / 1ps
module comb_allpass_reverb_tb;
   import car_pkg::*;

   // Register indexes past the last defined one; the block must ignore writes to them.
   localparam logic [2:0] REG_SPARE_A = 3'd6;
   localparam logic [2:0] REG_SPARE_B = 3'd7;
   // Cycles with no word moving on either channel before the run is declared hung. The
   // limit sits well above the length of the clearing pass after reset.
   localparam int STALL_LIMIT = 60000;
   // This pause covers the time the block spends on one word, with margin.
   localparam int SETTLE = 120;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;
   logic        calm;
   int          pending;
   int          errors;
   int          quiet_cycles;

   car_stream_if #(16) req_if ();
   car_stream_if #(16) rsp_if ();

   comb_allpass_reverb DUT (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   comb_allpass_reverb_checker checker_inst (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .pending   (pending),
      .errors    (errors)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // The output side stalls in about six percent of cycles, except in the calm stretch.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= calm || ($urandom_range(99) >= 6);
      end
   end

   // Watchdog: counts cycles in which no word moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("comb_allpass_reverb_tb: done, errors");
            $finish;
         end
      end
   end

   // Offers one dry word and holds it until the block takes it. Outside the calm stretch,
   // a random gap at times lets the source idle at varying points of the block's work.
   task automatic send_word(input logic [15:0] w);
      if (!calm && $urandom_range(99) < 6) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 70)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data <= w;
      do @(posedge clock); while (!req_if.ready);
   endtask

   // Mostly full-scale random words, with a share of small ones so that the tails
   // ring without sitting at the saturation limits.
   task automatic send_random(input int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(9) < 7) send_word(16'($urandom));
         else send_word(16'($signed($urandom_range(600)) - 300));
      end
   endtask

   // Register writes happen only once every expected word is back and the block
   // has had time to drain.
   task automatic wait_idle();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
   endtask

   task automatic write_all(input logic [15:0] fb, input logic [15:0] damp,
                            input logic [15:0] apg, input logic [15:0] wet,
                            input logic [15:0] dry, input logic [15:0] frz);
      write_reg(REG_FEEDBACK, fb);
      write_reg(REG_DAMPING, damp);
      write_reg(REG_AP_GAIN, apg);
      write_reg(REG_WET, wet);
      write_reg(REG_DRY, dry);
      write_reg(REG_FREEZE, frz);
      csr_we <= 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      calm = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_data = '0;
      req_if.valid = 1'b0;
      req_if.data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed words at the reset settings: extremes, signs, alternating bits and
      // an impulse followed by silence so the comb tails come back.
      send_word(16'h7FFF);
      send_word(16'h8000);
      send_word(16'h0000);
      send_word(16'hFFFF);
      send_word(16'h0001);
      send_word(16'h5555);
      send_word(16'hAAAA);
      send_word(16'h7FFF);
      send_word(16'h7FFF);
      send_word(16'h8000);
      send_word(16'h8000);
      send_word(16'h0000);
      send_word(16'h0000);
      send_word(16'h0000);
      send_random(100);

      // Unity feedback, no damping, largest allpass gain, full wet and no dry: the
      // internal signals pile up and must saturate at the 24-bit limits.
      wait_idle();
      write_all(16'd32768, 16'd0, 16'd32767, 16'd32768, 16'd0, 16'd0);
      send_random(120);

      // Freeze holds the tails at full feedback whatever the feedback register says.
      wait_idle();
      write_all(16'd0, 16'd32767, 16'd8192, 16'd32768, 16'd32768, 16'd1);
      send_random(100);

      // Wet path at its low end: no feedback, most damping, no allpass gain, dry only.
      wait_idle();
      write_all(16'd0, 16'd32767, 16'd0, 16'd0, 16'd32768, 16'd0);
      send_random(80);

      // Gains above unity are used as given; the damping and allpass writes carry a
      // top bit that must be dropped, freeze carries extra bits, and writes to the
      // spare indexes must change nothing.
      wait_idle();
      write_all(16'hFFFF, 16'hFFFF, 16'hC000, 16'hFFFF, 16'hFFFF, 16'hFFFE);
      write_reg(REG_SPARE_A, 16'h0000);
      write_reg(REG_SPARE_B, 16'hFFFF);
      csr_we <= 1'b0;
      send_random(100);

      // Random settings within the documented ranges; the first one runs without any
      // idling on either side.
      for (int p = 0; p < 5; p++) begin
         wait_idle();
         write_all(16'($urandom_range(32768)), 16'($urandom_range(32767)),
                   16'($urandom_range(32767)), 16'($urandom_range(32768)),
                   16'($urandom_range(32768)), 16'($urandom_range(3) == 0));
         calm = (p == 0);
         send_random(90);
         calm = 1'b0;
      end

      wait_idle();
      if (errors == 0) begin
         $display("comb_allpass_reverb_tb: done, clean");
      end else begin
         $display("comb_allpass_reverb_tb: done, errors");
      end
      $finish;
   end
endmodule
